[sv/cwu_pkg.sv]
// cwu_pkg: shared types and constants for the cpu window utilization block
// transaction payload structs, share scaling constants and the multiply shift table
// no dependencies

package cwu_pkg;

    // counter and field widths
    localparam int COUNTER_WIDTH_DEF = 64;
    localparam int FIELD_W           = 64;
    localparam int SHARE_W           = 17;

    // share scale is 100000 = 2^16 + 2^15 + 2^10 + 2^9 + 2^7 + 2^5
    localparam int SHARE_SCALE = 100000;
    localparam int MUL_TERMS   = 6;
    localparam int MUL_IDX_W   = $clog2(MUL_TERMS);
    localparam int SHIFT_W     = $clog2(SHARE_W);
    localparam int STEP_W      = $clog2(SHARE_W);

    // input transaction
    typedef struct packed {
        logic [FIELD_W-1:0] wall_cycles;
        logic [FIELD_W-1:0] idle_cycles;
    } t_in;

    // output transaction
    typedef struct packed {
        logic               first_sample;
        logic [SHARE_W-1:0] work_share_milli;
        logic [SHARE_W-1:0] idle_share_milli;
        logic [FIELD_W-1:0] window_total;
        logic [FIELD_W-1:0] window_idle;
        logic [FIELD_W-1:0] window_work;
    } t_out;

    // shift amount of each set bit of the share scale
    function automatic logic [SHIFT_W-1:0] mul_shift(input logic [MUL_IDX_W-1:0] idx);
        logic [SHIFT_W-1:0] sh;
        sh = '0;
        case (idx)
            3'd0:    sh = SHIFT_W'(16);
            3'd1:    sh = SHIFT_W'(15);
            3'd2:    sh = SHIFT_W'(10);
            3'd3:    sh = SHIFT_W'(9);
            3'd4:    sh = SHIFT_W'(7);
            3'd5:    sh = SHIFT_W'(5);
            default: sh = '0;
        endcase
        return sh;
    endfunction

endpackage

[sv/cpu_window_utilization.sv]
// cpu_window_utilization: top level, window differences and share computation
// one shared add/subtract unit under a small sequencer; uses cwu_pkg
// results leave through an output register

// Takes snapshots of a wall-cycle counter and an idle-cycle counter and reports,
// for the window since the previous snapshot, the total, clamped idle and work
// cycle counts plus work and idle shares in thousandths of a percent (rounded
// half up, zero for an empty window). The first snapshot after reset only
// primes the stored state and returns a result flagged first_sample with all
// other fields zero. Every later snapshot runs from acceptance to the result
// register through window differences and clamping (S_TOT, S_IDL, S_CLP), then
// for each share a shift-add scale multiply over the 6 set bits of the scale,
// one rounding add and 17 restoring-division steps, all on one adder of
// COUNTER_WIDTH+17 bits; an empty window skips the shares. Input stall is high
// while a snapshot is in work. A finished result may wait in the output
// register while the next snapshot is accepted.

module cpu_window_utilization #(
    parameter int COUNTER_WIDTH = cwu_pkg::COUNTER_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  cwu_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cwu_pkg::t_out o_out
);

    localparam int W  = COUNTER_WIDTH;
    localparam int SW = cwu_pkg::SHARE_W;
    localparam int DW = W + SW;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TOT  = 3'd1;
    localparam logic [2:0] S_IDL  = 3'd2;
    localparam logic [2:0] S_CLP  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_HALF = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_primed, n_primed;
    logic [W-1:0] r_last_wall, n_last_wall;
    logic [W-1:0] r_last_idle, n_last_idle;
    logic       r_out_valid, n_out_valid;
    logic [cwu_pkg::STEP_W-1:0] r_step, n_step;
    logic       r_pass, n_pass;

    logic [W-1:0]  r_wall, n_wall;
    logic [W-1:0]  r_idle, n_idle;
    logic [W-1:0]  r_total, n_total;
    logic [W-1:0]  r_widle, n_widle;
    logic [W-1:0]  r_work, n_work;
    logic [DW-1:0] r_acc, n_acc;
    logic [W-1:0]  r_rem, n_rem;
    logic [SW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_work_s, n_work_s;
    logic [SW-1:0] r_idle_s, n_idle_s;
    logic          r_first, n_first;
    cwu_pkg::t_out r_out, n_out;

    logic          in_acc;
    logic          out_acc;
    logic [DW-1:0] alu_a, alu_b, alu_y;
    logic          alu_sub;
    logic          alu_neg;
    logic [W-1:0]  part;
    logic [W:0]    div_shift;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign part      = r_pass ? r_widle : r_work;
    assign div_shift = {r_rem, r_quo[SW-1]};

    // operand selection for the shared adder
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (r_state)
            S_TOT: begin
                alu_a = {{SW{1'b0}}, r_wall};
                alu_b = {{SW{1'b0}}, r_last_wall};
            end
            S_IDL: begin
                alu_a = {{SW{1'b0}}, r_idle};
                alu_b = {{SW{1'b0}}, r_last_idle};
            end
            S_CLP: begin
                alu_a = {{SW{1'b0}}, r_total};
                alu_b = {{SW{1'b0}}, r_widle};
            end
            S_MUL: begin
                alu_a   = r_acc;
                alu_b   = {{SW{1'b0}}, part}
                          << cwu_pkg::mul_shift(r_step[cwu_pkg::MUL_IDX_W-1:0]);
                alu_sub = 1'b0;
            end
            S_HALF: begin
                alu_a   = r_acc;
                alu_b   = {{(SW+1){1'b0}}, r_total[W-1:1]};
                alu_sub = 1'b0;
            end
            S_DIV: begin
                alu_a = {{(SW-1){1'b0}}, div_shift};
                alu_b = {{SW{1'b0}}, r_total};
            end
            S_IDLE, S_DONE: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    // shared adder; in the subtracting states the operands stay far below the top bit, so it is the borrow
    assign alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_neg = alu_y[DW-1];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_primed    = r_primed;
        n_last_wall = r_last_wall;
        n_last_idle = r_last_idle;
        n_out_valid = r_out_valid && !out_acc;
        n_step      = r_step;
        n_pass      = r_pass;
        n_wall      = r_wall;
        n_idle      = r_idle;
        n_total     = r_total;
        n_widle     = r_widle;
        n_work      = r_work;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_work_s    = r_work_s;
        n_idle_s    = r_idle_s;
        n_first     = r_first;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_wall = i_in.wall_cycles[W-1:0];
                    n_idle = i_in.idle_cycles[W-1:0];
                    if (!r_primed) begin
                        // priming snapshot: store it and report zeros
                        n_primed    = 1'b1;
                        n_last_wall = i_in.wall_cycles[W-1:0];
                        n_last_idle = i_in.idle_cycles[W-1:0];
                        n_first     = 1'b1;
                        n_total     = '0;
                        n_widle     = '0;
                        n_work      = '0;
                        n_work_s    = '0;
                        n_idle_s    = '0;
                        n_state     = S_DONE;
                    end else begin
                        n_first = 1'b0;
                        n_state = S_TOT;
                    end
                end
            end
            S_TOT: begin
                n_total = alu_y[W-1:0];
                n_state = S_IDL;
            end
            S_IDL: begin
                n_widle     = alu_y[W-1:0];
                n_last_wall = r_wall;
                n_last_idle = r_idle;
                n_state     = S_CLP;
            end
            S_CLP: begin
                // clamp idle to total
                if (alu_neg) begin
                    n_widle = r_total;
                    n_work  = '0;
                end else begin
                    n_work = alu_y[W-1:0];
                end
                n_work_s = '0;
                n_idle_s = '0;
                n_pass   = 1'b0;
                n_acc    = '0;
                n_step   = '0;
                if (r_total == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_acc = alu_y;
                if (r_step == cwu_pkg::STEP_W'(cwu_pkg::MUL_TERMS - 1)) begin
                    n_step  = '0;
                    n_state = S_HALF;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_HALF: begin
                // top bits of the dividend are already below total
                n_rem   = alu_y[DW-1:SW];
                n_quo   = alu_y[SW-1:0];
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                // one restoring division step
                n_rem = alu_neg ? div_shift[W-1:0] : alu_y[W-1:0];
                n_quo = {r_quo[SW-2:0], !alu_neg};
                if (r_step == cwu_pkg::STEP_W'(SW - 1)) begin
                    n_step = '0;
                    if (!r_pass) begin
                        n_work_s = n_quo;
                        n_pass   = 1'b1;
                        n_acc    = '0;
                        n_state  = S_MUL;
                    end else begin
                        n_idle_s = n_quo;
                        n_state  = S_DONE;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DONE: begin
                // load the output register once it is free
                if (!r_out_valid || out_acc) begin
                    n_out.first_sample     = r_first;
                    n_out.work_share_milli = r_work_s;
                    n_out.idle_share_milli = r_idle_s;
                    n_out.window_total     = cwu_pkg::FIELD_W'(r_total);
                    n_out.window_idle      = cwu_pkg::FIELD_W'(r_widle);
                    n_out.window_work      = cwu_pkg::FIELD_W'(r_work);
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_primed    <= 1'b0;
            r_last_wall <= '0;
            r_last_idle <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_pass      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_primed    <= n_primed;
            r_last_wall <= n_last_wall;
            r_last_idle <= n_last_idle;
            r_out_valid <= n_out_valid;
            r_step      <= n_step;
            r_pass      <= n_pass;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_wall   <= n_wall;
        r_idle   <= n_idle;
        r_total  <= n_total;
        r_widle  <= n_widle;
        r_work   <= n_work;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_work_s <= n_work_s;
        r_idle_s <= n_idle_s;
        r_first  <= n_first;
        r_out    <= n_out;
    end

`ifndef ASSERT_OFF
    // division remainder stays below the divisor
    a_rem_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_total))
        else $error("division remainder not below window total");

    // share passes only run on a nonempty window
    a_mul_nonzero_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_total != '0))
        else $error("share computed for empty window");

    // work and clamped idle add up to the window total
    a_window_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out.window_work + r_out.window_idle) == r_out.window_total))
        else $error("window work plus idle differs from total");

    // rounded shares add up to full scale, or one above on a double tie
    a_share_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.window_total != '0)) |->
        (((18'(r_out.work_share_milli) + 18'(r_out.idle_share_milli))
            == 18'(cwu_pkg::SHARE_SCALE)) ||
         ((18'(r_out.work_share_milli) + 18'(r_out.idle_share_milli))
            == 18'(cwu_pkg::SHARE_SCALE + 1))))
        else $error("work and idle shares do not sum to full scale");

    // a priming result carries nothing but the flag
    a_first_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.first_sample) |->
        ((r_out.window_total == '0) && (r_out.work_share_milli == '0) &&
         (r_out.idle_share_milli == '0)))
        else $error("priming result has nonzero fields");
`endif

endmodule

[verif/tb_top.sv]
// tb_top: self-checking testbench for cpu_window_utilization
// directed and random counter snapshots with bursty input and stalled output
// depends on cwu_pkg and cpu_window_utilization

module tb_top;

    localparam int CW = cwu_pkg::COUNTER_WIDTH_DEF;
    localparam logic [63:0] CNT_MASK = {64{1'b1}} >> (64 - CW);
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 64;
    localparam int RANDOM_WINDOWS = 600;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    cwu_pkg::t_in i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    cwu_pkg::t_out o_out;

    // window predictor state
    logic primed = 1'b0;
    logic [63:0] last_wall = '0;
    logic [63:0] last_idle = '0;

    // running counters seen by the sender
    logic [63:0] cur_wall = '0;
    logic [63:0] cur_idle = '0;

    cwu_pkg::t_out expected_windows[$];
    int error_count = 0;
    int cycle_count = 0;

    // sender burst control
    bit sender_gaps = 1'b1;
    int burst_left = 4;

    // receiver stall control
    int hold_request = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int stall_phase = 0;
    logic [7:0] stall_pattern = 8'h00;

    cpu_window_utilization #(
        .COUNTER_WIDTH(CW)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // share in thousandths of a percent, rounded half up, exact
    function automatic logic [cwu_pkg::SHARE_W-1:0] scaled_share(
        input logic [63:0] part,
        input logic [63:0] total
    );
        logic [127:0] num;
        num = {64'd0, part} * 128'(cwu_pkg::SHARE_SCALE) + {65'd0, total[63:1]};
        return cwu_pkg::SHARE_W'(num / {64'd0, total});
    endfunction

    // expected result for one snapshot, advances the stored window state
    function automatic cwu_pkg::t_out predict_window(input cwu_pkg::t_in snap);
        cwu_pkg::t_out res;
        logic [63:0] wall;
        logic [63:0] idle;
        logic [63:0] total;
        logic [63:0] widle;
        res = '0;
        wall = snap.wall_cycles & CNT_MASK;
        idle = snap.idle_cycles & CNT_MASK;
        if (primed) begin
            total = (wall - last_wall) & CNT_MASK;
            widle = (idle - last_idle) & CNT_MASK;
            if (widle > total) begin
                widle = total;
            end
            res.window_total = total;
            res.window_idle = widle;
            res.window_work = total - widle;
            if (total != 0) begin
                res.work_share_milli = scaled_share(total - widle, total);
                res.idle_share_milli = scaled_share(widle, total);
            end
        end else begin
            primed = 1'b1;
            res.first_sample = 1'b1;
        end
        last_wall = wall;
        last_idle = idle;
        return res;
    endfunction

    // random value of random bit length
    function automatic logic [63:0] rand_span();
        return {$urandom(), $urandom()} >> $urandom_range(0, 63);
    endfunction

    // offer one snapshot until accepted, then maybe pause
    task automatic send_snapshot(input logic [63:0] wall, input logic [63:0] idle);
        cwu_pkg::t_in snap;
        int gap;
        snap.wall_cycles = wall;
        snap.idle_cycles = idle;
        i_in_valid <= 1'b1;
        i_in <= snap;
        do @(posedge i_clk); while (o_in_stall);
        expected_windows.push_back(predict_window(snap));
        cur_wall = wall;
        cur_idle = idle;
        if (sender_gaps) begin
            if (burst_left > 0) begin
                burst_left--;
            end
            if (burst_left == 0) begin
                gap = $urandom_range(1, 12);
                burst_left = $urandom_range(1, 8);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // advance both counters by the given window
    task automatic send_window(input logic [63:0] dwall, input logic [63:0] didle);
        send_snapshot(cur_wall + dwall, cur_idle + didle);
    endtask

    // first snapshot, empty window, wrap, rounding and clamping
    task automatic test_edge_windows();
        send_snapshot('1, '1);
        send_snapshot('1, '1);
        send_snapshot('0, '0);
        send_window(64'd1, 64'd0);
        send_window(64'd3, 64'd1);
        send_window(64'd3, 64'd2);
        send_window(64'd200000, 64'd1);
        send_window(64'd200000, 64'd199999);
        send_window(64'd1, 64'd1);
        send_window('1, 64'd0);
        send_window('1, '1);
        send_window(64'd5, 64'd9);
        send_window(64'd0, 64'd7);
        send_window(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
        send_snapshot(64'h0, 64'hffff_ffff_ffff_ffff);
        send_snapshot(64'hffff_ffff_ffff_ffff, 64'h0);
        send_snapshot(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_snapshot(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_window(64'h0000_0001_0000_0000, 64'h0000_0000_8000_0000);
        send_window(64'd100000, 64'd33333);
    endtask

    // mostly consistent counter windows with some noise snapshots
    task automatic test_random_windows(input int count);
        logic [63:0] dwall;
        logic [63:0] didle;
        logic [63:0] wide;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                sender_gaps = ($urandom_range(0, 3) != 0);
            end
            case ($urandom_range(0, 19))
                0: begin
                    send_snapshot({$urandom(), $urandom()}, {$urandom(), $urandom()});
                end
                1: begin
                    send_window(64'd0, rand_span());
                end
                default: begin
                    dwall = rand_span();
                    wide = {$urandom(), $urandom()};
                    case ($urandom_range(0, 9))
                        0: didle = dwall + 64'd1 + rand_span();
                        1: didle = dwall;
                        2: didle = '0;
                        default: didle = (dwall == '1) ? wide : wide % (dwall + 64'd1);
                    endcase
                    send_window(dwall, didle);
                end
            endcase
        end
        sender_gaps = 1'b1;
    endtask

    // long output hold-off while snapshots keep coming
    task automatic test_output_holdoff();
        sender_gaps = 1'b0;
        hold_request = 400;
        for (int n = 0; n < 20; n++) begin
            send_window(rand_span(), rand_span());
        end
        sender_gaps = 1'b1;
    endtask

    // result checker and output stall pattern
    always @(posedge i_clk) begin
        cwu_pkg::t_out exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_windows.size() == 0) begin
                $error("unexpected transaction on output");
                error_count++;
            end else begin
                exp_res = expected_windows.pop_front();
                if (o_out.first_sample !== exp_res.first_sample) begin
                    $error("first_sample: expected %0d actual %0d",
                           exp_res.first_sample, o_out.first_sample);
                    error_count++;
                end
                if (o_out.work_share_milli !== exp_res.work_share_milli) begin
                    $error("work_share_milli: expected %0d actual %0d",
                           exp_res.work_share_milli, o_out.work_share_milli);
                    error_count++;
                end
                if (o_out.idle_share_milli !== exp_res.idle_share_milli) begin
                    $error("idle_share_milli: expected %0d actual %0d",
                           exp_res.idle_share_milli, o_out.idle_share_milli);
                    error_count++;
                end
                if (o_out.window_total !== exp_res.window_total) begin
                    $error("window_total: expected %0h actual %0h",
                           exp_res.window_total, o_out.window_total);
                    error_count++;
                end
                if (o_out.window_idle !== exp_res.window_idle) begin
                    $error("window_idle: expected %0h actual %0h",
                           exp_res.window_idle, o_out.window_idle);
                    error_count++;
                end
                if (o_out.window_work !== exp_res.window_work) begin
                    $error("window_work: expected %0h actual %0h",
                           exp_res.window_work, o_out.window_work);
                    error_count++;
                end
            end
        end

        // pick a new stall pattern every so often
        stall_phase++;
        if (stall_phase >= 97) begin
            stall_phase = 0;
            stall_mode = $urandom_range(0, 3);
            stall_pattern = 8'($urandom());
        end
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                2: i_out_stall <= stall_pattern[stall_phase % 8];
                default: i_out_stall <= ($urandom_range(0, 15) < 11);
            endcase
        end
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // test sequence
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_windows();
        test_output_holdoff();
        test_random_windows(RANDOM_WINDOWS);
        i_in_valid <= 1'b0;
        while (expected_windows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
sv/cwu_pkg.sv
sv/cpu_window_utilization.sv
verif/tb_top.sv
